// ----- hw/rtl/crcfr_pkg.sv -----
// Shared types, constants and the CRC16 byte update for the frame receiver.
// No dependencies; every other file of the block imports this package.
package crcfr_pkg;

   localparam int MAX_PAYLOAD_DEF = 64;
   localparam int QUEUE_DEPTH     = 2;
   localparam int RESERVED_BYTES  = 4;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] HEADER_FIRST_RST  = 8'd170;
   localparam logic [7:0] HEADER_SECOND_RST = 8'd85;
   localparam logic [6:0] MAX_LEN_RST       = 7'd64;

   // register indexes on the configuration port
   localparam logic [1:0] CSR_HEADER_FIRST  = 2'd0;
   localparam logic [1:0] CSR_HEADER_SECOND = 2'd1;
   localparam logic [1:0] CSR_MAX_LEN       = 2'd2;

   // result status codes
   localparam logic [1:0] ST_GOOD   = 2'd0;
   localparam logic [1:0] ST_HEADER = 2'd1;
   localparam logic [1:0] ST_LENGTH = 2'd2;
   localparam logic [1:0] ST_CRC    = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_CMD,
      PH_LEN,
      PH_DATA,
      PH_RESERVED,
      PH_CRC
   } phase_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_READ,
      B_SHOW
   } back_state_type;

   // one finished frame or error, handed from parser to emitter
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] command;
      logic [6:0]  payload_len;
      logic [31:0] good_count;
      logic [31:0] error_count;
   } job_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/crc_frame_receiver.sv -----
// Frame receiver with CRC16 check. The parser takes one byte per cycle; it holds
// off when the job queue is full, and holds off payload bytes while the emitter
// still reads the payload store. A frame's first result is shown once its job has
// passed the queue and the emitter's store read; each result then takes a store read and a show.
// Synchronous reset clears parser, counters, queue and emitter and restores the
// register defaults; the payload store is not cleared.
module crc_frame_receiver
   import crcfr_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_command,
   output logic [6:0]  rsp_payload_len,
   output logic [7:0]  rsp_data_byte,
   output logic [5:0]  rsp_data_index,
   output logic        rsp_last,
   output logic [31:0] rsp_good_count,
   output logic [31:0] rsp_error_count
);

   localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic             push, pop, q_not_empty, q_full, back_busy, mem_busy;
   job_type          push_job, head_job;
   logic             pay_we;
   logic [IDX_W-1:0] pay_addr;
   logic [7:0]       pay_data;

   assign mem_busy = q_not_empty || back_busy;

   crcfr_front #(.MAX_PAYLOAD(MAX_PAYLOAD), .IDX_W(IDX_W)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_full      (q_full),
      .mem_busy    (mem_busy),
      .push        (push),
      .push_job    (push_job),
      .pay_we      (pay_we),
      .pay_addr    (pay_addr),
      .pay_data    (pay_data)
   );

   crcfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .head_job  (head_job),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   crcfr_back #(.MAX_PAYLOAD(MAX_PAYLOAD), .IDX_W(IDX_W)) u_back (
      .clock           (clock),
      .reset           (reset),
      .pay_we          (pay_we),
      .pay_addr        (pay_addr),
      .pay_data        (pay_data),
      .q_not_empty     (q_not_empty),
      .head_job        (head_job),
      .pop             (pop),
      .busy            (back_busy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_command     (rsp_command),
      .rsp_payload_len (rsp_payload_len),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_data_index  (rsp_data_index),
      .rsp_last        (rsp_last),
      .rsp_good_count  (rsp_good_count),
      .rsp_error_count (rsp_error_count)
   );

endmodule

// ----- hw/rtl/crcfr_front.sv -----
// Frame parser: takes received bytes, checks header, length and CRC,
// writes payload bytes out and pushes one job per frame. Uses crcfr_pkg.
module crcfr_front
   import crcfr_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
   parameter int IDX_W       = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_rx_byte,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_wdata,
   input  logic             q_full,
   input  logic             mem_busy,
   output logic             push,
   output job_type          push_job,
   output logic             pay_we,
   output logic [IDX_W-1:0] pay_addr,
   output logic [7:0]       pay_data
);

   localparam logic [6:0] MAX_LEN = 7'(MAX_PAYLOAD);

   phase_type   phase_ff, phase_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [7:0]  first_hdr_ff, first_hdr_in;
   logic [15:0] cmd_ff, cmd_in;
   logic [7:0]  length_ff, length_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic [31:0] good_ff, good_in;
   logic [31:0] err_ff, err_in;
   logic [7:0]  hdr1_ff, hdr2_ff;
   logic [6:0]  max_len_ff;

   logic        accept;
   logic [6:0]  limit;
   logic        hdr_bad, len_bad, crc_bad;
   logic [15:0] crc_next;
   logic [7:0]  cnt_inc;

   assign accept   = req_valid && req_ready;
   assign limit    = (max_len_ff > MAX_LEN) ? MAX_LEN : max_len_ff;
   assign hdr_bad  = (first_hdr_ff != hdr1_ff) || (req_rx_byte != hdr2_ff);
   assign len_bad  = (req_rx_byte != 8'h00) || (length_ff > {1'b0, limit});
   assign crc_bad  = {req_rx_byte, crc_lo_ff} != crc_ff;
   assign crc_next = crc_feed(crc_ff, req_rx_byte);
   assign cnt_inc  = {1'b0, cnt_ff} + 8'd1;

   // next state and datapath
   always_comb begin
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      first_hdr_in = first_hdr_ff;
      cmd_in       = cmd_ff;
      length_in    = length_ff;
      crc_in       = crc_ff;
      crc_lo_in    = crc_lo_ff;
      good_in      = good_ff;
      err_in       = err_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               first_hdr_in = req_rx_byte;
               cnt_in       = '0;
               phase_in     = PH_HEADER;
            end
            PH_HEADER: begin
               if (hdr_bad) begin
                  err_in   = err_ff + 32'd1;
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_CMD;
                  cnt_in   = '0;
                  cmd_in   = '0;
                  crc_in   = CRC_INIT;
               end
            end
            PH_CMD: begin
               crc_in = crc_next;
               if (cnt_ff == 7'd0) begin
                  cmd_in = {8'h00, req_rx_byte};
                  cnt_in = 7'd1;
               end else begin
                  cmd_in   = {req_rx_byte, cmd_ff[7:0]};
                  cnt_in   = '0;
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               crc_in = crc_next;
               if (cnt_ff == 7'd0) begin
                  length_in = req_rx_byte;
                  cnt_in    = 7'd1;
               end else begin
                  cnt_in = '0;
                  if (len_bad) begin
                     err_in   = err_ff + 32'd1;
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = (length_ff != 8'd0) ? PH_DATA : PH_RESERVED;
                  end
               end
            end
            PH_DATA: begin
               crc_in = crc_next;
               cnt_in = cnt_inc[6:0];
               if (cnt_inc >= length_ff) begin
                  cnt_in   = '0;
                  phase_in = PH_RESERVED;
               end
            end
            PH_RESERVED: begin
               crc_in = crc_next;
               cnt_in = cnt_inc[6:0];
               if (cnt_inc >= 8'(RESERVED_BYTES)) begin
                  cnt_in   = '0;
                  phase_in = PH_CRC;
               end
            end
            PH_CRC: begin
               if (cnt_ff == 7'd0) begin
                  crc_lo_in = req_rx_byte;
                  cnt_in    = 7'd1;
               end else begin
                  cnt_in   = '0;
                  phase_in = PH_IDLE;
                  if (crc_bad) begin
                     err_in = err_ff + 32'd1;
                  end else begin
                     good_in = good_ff + 32'd1;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
               cnt_in   = '0;
            end
         endcase
      end
   end

   // handshake, job push and payload write
   always_comb begin
      // hold off payload bytes while the emitter still reads the store
      req_ready = !q_full && !((phase_ff == PH_DATA) && mem_busy);
      push      = 1'b0;
      push_job  = '0;
      pay_we    = 1'b0;
      pay_addr  = cnt_ff[IDX_W-1:0];
      pay_data  = req_rx_byte;
      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (hdr_bad) begin
                  push     = 1'b1;
                  push_job = '{status: ST_HEADER, command: '0, payload_len: '0,
                               good_count: good_ff, error_count: err_ff + 32'd1};
               end
            end
            PH_LEN: begin
               if (cnt_ff != 7'd0 && len_bad) begin
                  push     = 1'b1;
                  push_job = '{status: ST_LENGTH, command: '0, payload_len: '0,
                               good_count: good_ff, error_count: err_ff + 32'd1};
               end
            end
            PH_DATA: begin
               pay_we = 1'b1;
            end
            PH_CRC: begin
               if (cnt_ff != 7'd0) begin
                  push = 1'b1;
                  if (crc_bad) begin
                     push_job = '{status: ST_CRC, command: '0, payload_len: '0,
                                  good_count: good_ff, error_count: err_ff + 32'd1};
                  end else begin
                     push_job = '{status: ST_GOOD, command: cmd_ff,
                                  payload_len: length_ff[6:0],
                                  good_count: good_ff + 32'd1, error_count: err_ff};
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         cnt_ff     <= '0;
         crc_ff     <= CRC_INIT;
         good_ff    <= '0;
         err_ff     <= '0;
         hdr1_ff    <= HEADER_FIRST_RST;
         hdr2_ff    <= HEADER_SECOND_RST;
         max_len_ff <= MAX_LEN_RST;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         crc_ff   <= crc_in;
         good_ff  <= good_in;
         err_ff   <= err_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_HEADER_FIRST:  hdr1_ff    <= csr_wdata;
               CSR_HEADER_SECOND: hdr2_ff    <= csr_wdata;
               CSR_MAX_LEN:       max_len_ff <= csr_wdata[6:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      first_hdr_ff <= first_hdr_in;
      cmd_ff       <= cmd_in;
      length_ff    <= length_in;
      crc_lo_ff    <= crc_lo_in;
   end

endmodule

// ----- hw/rtl/crcfr_queue.sv -----
// Short job queue between parser and emitter.
// Depends on crcfr_pkg for job_type and the queue depth.
module crcfr_queue
   import crcfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    not_empty,
   output logic    full
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   job_type          slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign not_empty = count_ff != '0;
   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head_job  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- hw/rtl/crcfr_back.sv -----
// Result emitter: holds the payload store, pops jobs and presents one
// result per payload byte (or one per error / empty frame). Uses crcfr_pkg.
module crcfr_back
   import crcfr_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
   parameter int IDX_W       = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             pay_we,
   input  logic [IDX_W-1:0] pay_addr,
   input  logic [7:0]       pay_data,
   input  logic             q_not_empty,
   input  job_type          head_job,
   output logic             pop,
   output logic             busy,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_command,
   output logic [6:0]       rsp_payload_len,
   output logic [7:0]       rsp_data_byte,
   output logic [5:0]       rsp_data_index,
   output logic             rsp_last,
   output logic [31:0]      rsp_good_count,
   output logic [31:0]      rsp_error_count
);

   back_state_type   state_ff, state_in;
   job_type          job_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [7:0]       rd_data_ff;
   logic [7:0]       store_mem [MAX_PAYLOAD];
   logic             is_last;

   assign is_last = (job_ff.payload_len == 7'd0)
                    || ((7'(idx_ff) + 7'd1) == job_ff.payload_len);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (q_not_empty) state_in = B_READ;
         B_READ: state_in = B_SHOW;
         B_SHOW: if (rsp_ready) state_in = is_last ? B_IDLE : B_READ;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      pop       = (state_ff == B_IDLE) && q_not_empty;
      busy      = state_ff != B_IDLE;
      rsp_valid = state_ff == B_SHOW;
   end

   assign rsp_status      = job_ff.status;
   assign rsp_command     = job_ff.command;
   assign rsp_payload_len = job_ff.payload_len;
   assign rsp_data_byte   = (job_ff.payload_len != 7'd0) ? rd_data_ff : 8'h00;
   assign rsp_data_index  = 6'(idx_ff);
   assign rsp_last        = is_last;
   assign rsp_good_count  = job_ff.good_count;
   assign rsp_error_count = job_ff.error_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head_job;
         idx_ff <= '0;
      end else if (state_ff == B_SHOW && rsp_ready && !is_last) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pay_we) begin
         store_mem[pay_addr] <= pay_data;
      end
      if (state_ff == B_READ) begin
         rd_data_ff <= store_mem[idx_ff];
      end
   end

endmodule

// ----- hw/rtl/crcfr_checker.sv -----
// Port-level checks on the result channel of the frame receiver.
// Depends on crcfr_pkg status codes; bound to crc_frame_receiver below.
module crcfr_checker
   import crcfr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_command,
   input logic [6:0]  rsp_payload_len,
   input logic [7:0]  rsp_data_byte,
   input logic [5:0]  rsp_data_index,
   input logic        rsp_last,
   input logic [31:0] rsp_good_count,
   input logic [31:0] rsp_error_count
);

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_data_index) && $stable(rsp_good_count))
      else $error("stalled result changed");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_GOOD |->
         rsp_last && rsp_command == 16'd0 && rsp_payload_len == 7'd0)
      else $error("error result not a single cleared transfer");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_len != 7'd0 |->
         {1'b0, rsp_data_index} < rsp_payload_len)
      else $error("payload index beyond length");

   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_len == 7'd0 |->
         rsp_last && rsp_data_index == 6'd0 && rsp_data_byte == 8'd0)
      else $error("empty payload result malformed");

endmodule

bind crc_frame_receiver crcfr_checker u_checker (.*);

// ----- tb/crc_frame_receiver_tb.sv -----
// Self-checking testbench for the CRC16 frame receiver: directed and random byte streams,
// predicted results checked field by field. Depends on crcfr_pkg and crc_frame_receiver.
module crc_frame_receiver_tb;
   import crcfr_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int CFG_SETTLE   = 8;
   localparam int END_SETTLE   = 20;
   localparam int MAX_MISMATCH = 10;
   localparam int RANDOM_BYTES = 8;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] command;
      logic [6:0]  payload_len;
      logic [7:0]  data_byte;
      logic [5:0]  data_index;
      logic        last;
      logic [31:0] good_count;
      logic [31:0] error_count;
   } frame_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_command;
   logic [6:0]  rsp_payload_len;
   logic [7:0]  rsp_data_byte;
   logic [5:0]  rsp_data_index;
   logic        rsp_last;
   logic [31:0] rsp_good_count;
   logic [31:0] rsp_error_count;

   // register mirror
   logic [7:0]  cfg_hdr1    = HEADER_FIRST_RST;
   logic [7:0]  cfg_hdr2    = HEADER_SECOND_RST;
   logic [6:0]  cfg_max_len = MAX_LEN_RST;

   // parser mirror
   phase_type   rx_phase  = PH_IDLE;
   int          rx_pos    = 0;
   logic [7:0]  rx_first  = '0;
   logic [15:0] rx_cmd    = '0;
   logic [15:0] rx_len    = '0;
   logic [15:0] rx_crc    = CRC_INIT;
   logic [7:0]  rx_crc_lo = '0;
   logic [7:0]  rx_store [MAX_PAYLOAD_DEF];
   logic [31:0] rx_good   = '0;
   logic [31:0] rx_bad    = '0;

   frame_result_type parsed_results[$];
   int bytes_sent        = 0;
   int fail_count        = 0;
   int stall_left        = 0;
   bit gaps_on           = 1'b1;
   bit stalls_on         = 1'b1;

   crc_frame_receiver dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_command     (rsp_command),
      .rsp_payload_len (rsp_payload_len),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_data_index  (rsp_data_index),
      .rsp_last        (rsp_last),
      .rsp_good_count  (rsp_good_count),
      .rsp_error_count (rsp_error_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // bit-serial reflected CRC16, least significant bit first
   function automatic logic [15:0] modbus_crc_next(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int n = 0; n < 8; n++) begin
         fb = r[0] ^ d[n];
         r  = r >> 1;
         if (fb) r = r ^ CRC_POLY;
      end
      return r;
   endfunction

   function automatic int payload_limit();
      return (cfg_max_len > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : int'(cfg_max_len);
   endfunction

   function automatic int pick_gap(input bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic void push_result(input logic [1:0] st, input logic [15:0] cmd,
                                       input logic [6:0] plen, input logic [7:0] db,
                                       input logic [5:0] idx, input logic lst);
      frame_result_type r;
      r = '{st, cmd, plen, db, idx, lst, rx_good, rx_bad};
      parsed_results.push_back(r);
   endfunction

   function automatic void flag_frame_error(input logic [1:0] code);
      rx_bad++;
      rx_phase = PH_IDLE;
      push_result(code, 16'h0000, 7'd0, 8'h00, 6'd0, 1'b1);
   endfunction

   // advance the parser mirror by one received byte
   function automatic void parse_byte(input logic [7:0] b);
      case (rx_phase)
         PH_IDLE: begin
            rx_first = b;
            rx_pos   = 0;
            rx_phase = PH_HEADER;
         end
         PH_HEADER: begin
            if (rx_first != cfg_hdr1 || b != cfg_hdr2) begin
               flag_frame_error(ST_HEADER);
            end else begin
               rx_phase = PH_CMD;
               rx_pos   = 0;
               rx_cmd   = '0;
               rx_len   = '0;
               rx_crc   = CRC_INIT;
            end
         end
         PH_CMD: begin
            rx_crc = modbus_crc_next(rx_crc, b);
            if (rx_pos == 0) begin
               rx_cmd = {8'h00, b};
               rx_pos = 1;
            end else begin
               rx_cmd[15:8] = b;
               rx_pos       = 0;
               rx_phase     = PH_LEN;
            end
         end
         PH_LEN: begin
            rx_crc = modbus_crc_next(rx_crc, b);
            if (rx_pos == 0) begin
               rx_len = {8'h00, b};
               rx_pos = 1;
            end else begin
               rx_len[15:8] = b;
               rx_pos       = 0;
               if (rx_len > payload_limit()) flag_frame_error(ST_LENGTH);
               else rx_phase = (rx_len != 0) ? PH_DATA : PH_RESERVED;
            end
         end
         PH_DATA: begin
            rx_crc = modbus_crc_next(rx_crc, b);
            if (rx_pos < MAX_PAYLOAD_DEF) rx_store[rx_pos] = b;
            rx_pos++;
            if (rx_pos >= rx_len) begin
               rx_pos   = 0;
               rx_phase = PH_RESERVED;
            end
         end
         PH_RESERVED: begin
            rx_crc = modbus_crc_next(rx_crc, b);
            rx_pos++;
            if (rx_pos >= RESERVED_BYTES) begin
               rx_pos   = 0;
               rx_phase = PH_CRC;
            end
         end
         PH_CRC: begin
            if (rx_pos == 0) begin
               rx_crc_lo = b;
               rx_pos    = 1;
            end else begin
               rx_pos = 0;
               if ({b, rx_crc_lo} != rx_crc) begin
                  flag_frame_error(ST_CRC);
               end else begin
                  rx_phase = PH_IDLE;
                  rx_good++;
                  if (rx_len == 0) begin
                     push_result(ST_GOOD, rx_cmd, 7'd0, 8'h00, 6'd0, 1'b1);
                  end else begin
                     for (int i = 0; i < rx_len && i < MAX_PAYLOAD_DEF; i++)
                        push_result(ST_GOOD, rx_cmd, rx_len[6:0], rx_store[i], 6'(i),
                                    (i + 1 == rx_len));
                  end
               end
            end
         end
         default: begin
            rx_phase = PH_IDLE;
            rx_pos   = 0;
         end
      endcase
   endfunction

   function automatic string show_result(input frame_result_type r);
      return $sformatf("st=%0d cmd=%h len=%0d byte=%h idx=%0d last=%b good=%0d err=%0d",
                       r.status, r.command, r.payload_len, r.data_byte, r.data_index,
                       r.last, r.good_count, r.error_count);
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_MISMATCH) $display("mismatch: %s", msg);
   endtask

   task automatic check_result();
      frame_result_type seen;
      frame_result_type due;
      seen = '{rsp_status, rsp_command, rsp_payload_len, rsp_data_byte, rsp_data_index,
               rsp_last, rsp_good_count, rsp_error_count};
      if (parsed_results.size() == 0) begin
         note_failure({"unexpected result ", show_result(seen)});
      end else begin
         due = parsed_results.pop_front();
         if (seen.status !== due.status || seen.command !== due.command ||
             seen.payload_len !== due.payload_len || seen.data_byte !== due.data_byte ||
             seen.data_index !== due.data_index || seen.last !== due.last ||
             seen.good_count !== due.good_count || seen.error_count !== due.error_count)
            note_failure({"expected ", show_result(due), " got ", show_result(seen)});
      end
   endtask

   // result side: check each transfer, then pick the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            stall_left = pick_gap(stalls_on);
            rsp_ready <= (stall_left == 0);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("FAIL");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      parse_byte(b);
      bytes_sent++;
      gap = pick_gap(gaps_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold the sender until every predicted result has been taken
   task automatic wait_drained(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (parsed_results.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_HEADER_FIRST:  cfg_hdr1    = data;
         CSR_HEADER_SECOND: cfg_hdr2    = data;
         CSR_MAX_LEN:       cfg_max_len = data[6:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // a length over the limit ends the frame after the length field
   task automatic send_frame(input logic [15:0] cmd, input logic [15:0] len,
                             input logic [15:0] crc_flip, input bit extreme);
      logic [7:0]  frame_q[$];
      logic [15:0] crc;
      frame_q = '{cfg_hdr1, cfg_hdr2, cmd[7:0], cmd[15:8], len[7:0], len[15:8]};
      if (len <= payload_limit()) begin
         for (int i = 0; i < len; i++)
            frame_q.push_back(extreme ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom));
         for (int i = 0; i < RESERVED_BYTES; i++)
            frame_q.push_back(extreme ? ((i % 2) ? 8'h00 : 8'hFF) : 8'($urandom));
         crc = CRC_INIT;
         for (int k = 2; k < frame_q.size(); k++) crc = modbus_crc_next(crc, frame_q[k]);
         crc = crc ^ crc_flip;
         frame_q.push_back(crc[7:0]);
         frame_q.push_back(crc[15:8]);
      end
      foreach (frame_q[k]) send_byte(frame_q[k]);
   endtask

   task automatic sync_to_idle();
      while (rx_phase != PH_IDLE) send_byte(8'($urandom));
   endtask

   task automatic test_good_frames();
      send_frame(16'h0000, 16'd0, 16'h0000, 1'b1);
      send_frame(16'hFFFF, 16'd2, 16'h0000, 1'b1);
   endtask

   task automatic test_header_faults();
      send_byte(8'h00);
      send_byte(HEADER_SECOND_RST);
      send_byte(HEADER_FIRST_RST);
      send_byte(HEADER_FIRST_RST);
      // the second byte is not retried as a first header byte
      send_byte(HEADER_SECOND_RST);
      send_byte(8'hFF);
   endtask

   task automatic test_crc_faults();
      send_frame(16'h1234, 16'd3, 16'h0001, 1'b0);
      send_frame(16'h8001, 16'd1, 16'h8000, 1'b0);
   endtask

   task automatic test_length_limits();
      send_frame(16'h00FF, 16'd65, 16'h0000, 1'b0);
      send_frame(16'hFF00, 16'h0100, 16'h0000, 1'b0);
      send_frame(16'h5AA5, 16'hFFFF, 16'h0000, 1'b0);
      wait_drained(CFG_SETTLE);
      write_reg(CSR_MAX_LEN, 8'd0);
      send_frame(16'h0001, 16'd0, 16'h0000, 1'b0);
      send_frame(16'h0002, 16'd1, 16'h0000, 1'b0);
      wait_drained(CFG_SETTLE);
      // upper bit is dropped by the register and the limit clamps at the store size
      write_reg(CSR_MAX_LEN, 8'hFF);
      send_frame(16'hC0C1, 16'd64, 16'h0000, 1'b0);
      send_frame(16'hC0C2, 16'd65, 16'h0000, 1'b0);
   endtask

   task automatic test_header_registers();
      wait_drained(CFG_SETTLE);
      write_reg(CSR_HEADER_FIRST, 8'h00);
      write_reg(CSR_HEADER_SECOND, 8'hFF);
      send_frame(16'h0F0F, 16'd1, 16'h0000, 1'b0);
      wait_drained(CFG_SETTLE);
      write_reg(CSR_HEADER_FIRST, 8'hFF);
      write_reg(CSR_HEADER_SECOND, 8'h00);
      send_frame(16'hF0F0, 16'd2, 16'h0000, 1'b0);
      send_byte(HEADER_FIRST_RST);
      send_byte(HEADER_SECOND_RST);
      wait_drained(CFG_SETTLE);
      write_reg(CSR_UNUSED, 8'hA5);
      send_frame(16'h4321, 16'd1, 16'h0000, 1'b0);
   endtask

   task automatic test_random_traffic();
      int r;
      int lim;
      int start_bytes;
      for (int ph = 0; ph < 4; ph++) begin
         wait_drained(CFG_SETTLE);
         gaps_on   = (ph != 0);
         stalls_on = (ph != 0);
         write_reg(CSR_HEADER_FIRST, 8'($urandom));
         write_reg(CSR_HEADER_SECOND, 8'($urandom));
         write_reg(CSR_MAX_LEN, ($urandom_range(0, 99) < 40) ? 8'd64 : 8'($urandom));
         if (ph == 2) write_reg(CSR_UNUSED, 8'($urandom));
         lim         = payload_limit();
         start_bytes = bytes_sent;
         while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            sync_to_idle();
            r = $urandom_range(0, 99);
            if (r < 65) begin
               r = $urandom_range(0, 99);
               send_frame(16'($urandom),
                          (r < 70) ? 16'($urandom_range(0, (lim < 8) ? lim : 8)) :
                          (r < 92) ? 16'($urandom_range(0, lim)) : 16'(lim),
                          16'h0000, 1'b0);
            end else if (r < 75) begin
               send_frame(16'($urandom), 16'($urandom_range(0, (lim < 8) ? lim : 8)),
                          16'($urandom_range(1, 16'hFFFF)), 1'b0);
            end else if (r < 85) begin
               send_frame(16'($urandom), 16'($urandom_range(lim + 1, 16'hFFFF)),
                          16'h0000, 1'b0);
            end else if (r < 93) begin
               send_byte(($urandom_range(0, 1) != 0) ? cfg_hdr1 : 8'($urandom));
               send_byte(8'($urandom));
            end else begin
               repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
            end
         end
         sync_to_idle();
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= 8'h00;
      csr_we      <= 1'b0;
      csr_index   <= CSR_HEADER_FIRST;
      csr_wdata   <= 8'h00;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_good_frames();
      test_header_faults();
      test_crc_faults();
      test_length_limits();
      test_header_registers();
      test_random_traffic();

      wait_drained(END_SETTLE);
      if (fail_count == 0 && parsed_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/crcfr_pkg.sv
hw/rtl/crcfr_front.sv
hw/rtl/crcfr_queue.sv
hw/rtl/crcfr_back.sv
hw/rtl/crc_frame_receiver.sv
hw/rtl/crcfr_checker.sv
tb/crc_frame_receiver_tb.sv
